### rtl/xor_checked_report_frame_parser_macros.svh
// assertion macros shared by the report frame parser rtl
`ifndef XOR_CHECKED_REPORT_FRAME_PARSER_MACROS_SVH
`define XOR_CHECKED_REPORT_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define XCRFP_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define XCRFP_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/xcrfp_pkg.sv
// types and constants of the report frame parser
package xcrfp_pkg;

	localparam int BYTE_W    = 8;
	localparam int VALUE_W   = 16;
	localparam int POS_W     = 3;
	localparam int REG_IDX_W = 2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ACK   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NAK   = 2'd2;

	localparam logic [BYTE_W-1:0] START_RESET = 8'd0;
	localparam logic [BYTE_W-1:0] ACK_RESET   = 8'd6;
	localparam logic [BYTE_W-1:0] NAK_RESET   = 8'd21;

	// frame byte positions
	localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
	localparam logic [POS_W-1:0] POS_ID    = 3'd1;
	localparam logic [POS_W-1:0] POS_INDEX = 3'd2;
	localparam logic [POS_W-1:0] POS_VAL_H = 3'd3;
	localparam logic [POS_W-1:0] POS_VAL_L = 3'd4;
	localparam logic [POS_W-1:0] POS_CHECK = 3'd5;

	// beat op codes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] ack_code;
		logic [BYTE_W-1:0] nak_code;
	} codes_t;

	typedef struct packed {
		logic               ack_seen;
		logic               nak_seen;
		logic               report_ready;
		logic [BYTE_W-1:0]  report_id;
		logic [BYTE_W-1:0]  report_index;
		logic [VALUE_W-1:0] report_value;
	} result_t;

endpackage

### rtl/xcrfp_intf.sv
// valid/ready channels carrying input beats and result beats
interface xcrfp_in_if;
	import xcrfp_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface xcrfp_out_if;
	import xcrfp_pkg::*;

	logic               valid;
	logic               ready;
	logic               ack_seen;
	logic               nak_seen;
	logic               report_ready;
	logic [BYTE_W-1:0]  report_id;
	logic [BYTE_W-1:0]  report_index;
	logic [VALUE_W-1:0] report_value;

	modport source (output valid, output ack_seen, output nak_seen, output report_ready,
		output report_id, output report_index, output report_value, input ready);
	modport sink (input valid, input ack_seen, input nak_seen, input report_ready,
		input report_id, input report_index, input report_value, output ready);
endinterface

### rtl/xcrfp_cfg.sv
// configuration registers: start, ack and nak codes
module xcrfp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [xcrfp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [xcrfp_pkg::BYTE_W-1:0]    wr_data,
	output xcrfp_pkg::codes_t               codes
);
	import xcrfp_pkg::*;

	codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code <= START_RESET;
			codes_q.ack_code   <= ACK_RESET;
			codes_q.nak_code   <= NAK_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START: codes_q.start_code <= wr_data;
				REG_ACK:   codes_q.ack_code   <= wr_data;
				REG_NAK:   codes_q.nak_code   <= wr_data;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

### rtl/xcrfp_parse.sv
// frame parser state and per-beat update with xor check
module xcrfp_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         op,
	input  logic [xcrfp_pkg::BYTE_W-1:0] rx_byte,
	input  xcrfp_pkg::codes_t            codes,
	output xcrfp_pkg::result_t           result
);
	import xcrfp_pkg::*;

	logic               in_frame_q, in_frame_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [BYTE_W-1:0]  xor_q, xor_d;
	logic               held_q, held_d;
	logic [BYTE_W-1:0]  id_q, id_d;
	logic [BYTE_W-1:0]  index_q, index_d;
	logic [VALUE_W-1:0] value_q, value_d;
	logic               ack, nak;
	logic [BYTE_W-1:0]  xor_next;

	assign xor_next = xor_q ^ rx_byte;

	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		xor_d      = xor_q;
		held_d     = held_q;
		id_d       = id_q;
		index_d    = index_q;
		value_d    = value_q;
		ack        = 1'b0;
		nak        = 1'b0;
		if (op == OP_RELEASE) begin
			held_d = 1'b0;
		end else if (!in_frame_q && rx_byte == codes.ack_code) begin
			ack = 1'b1;
		end else if (!in_frame_q && rx_byte == codes.nak_code) begin
			nak = 1'b1;
		end else if (!held_q) begin
			if (!in_frame_q) begin
				if (rx_byte == codes.start_code) begin
					in_frame_d = 1'b1;
					pos_d      = POS_ID;
					xor_d      = rx_byte;
				end
			end else begin
				xor_d = xor_next;
				pos_d = pos_q + POS_W'(1);
				unique case (pos_q)
					POS_ID:    id_d = rx_byte;
					POS_INDEX: index_d = rx_byte;
					POS_VAL_H: value_d = {rx_byte, value_q[BYTE_W-1:0]};
					POS_VAL_L: value_d = {value_q[VALUE_W-1:BYTE_W], rx_byte};
					POS_CHECK: begin
						held_d     = (xor_next == '0);
						in_frame_d = 1'b0;
						pos_d      = POS_IDLE;
					end
					default: begin
						in_frame_d = 1'b0;
						pos_d      = POS_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= POS_IDLE;
			xor_q      <= '0;
			held_q     <= 1'b0;
			id_q       <= '0;
			index_q    <= '0;
			value_q    <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			xor_q      <= xor_d;
			held_q     <= held_d;
			id_q       <= id_d;
			index_q    <= index_d;
			value_q    <= value_d;
		end
	end

	always_comb begin
		result.ack_seen     = ack;
		result.nak_seen     = nak;
		result.report_ready = held_d;
		result.report_id    = held_d ? id_d : '0;
		result.report_index = held_d ? index_d : '0;
		result.report_value = held_d ? value_d : '0;
	end

`include "xor_checked_report_frame_parser_macros.svh"

	`XCRFP_ASSERT_IMPL(a_frame_excludes_held, 1'b1, !(in_frame_q && held_q), "frame while held")
	`XCRFP_ASSERT_IMPL(a_pos_in_range, in_frame_q, (pos_q >= POS_ID && pos_q <= POS_CHECK), "bad pos")
	`XCRFP_ASSERT_NEXT(a_release_clears, step && op == OP_RELEASE, !held_q, "release kept report")
	`XCRFP_ASSERT_IMPL(a_flag_outside_frame, step && (ack || nak), !in_frame_q && !(ack && nak), "flag")

endmodule

### rtl/xor_checked_report_frame_parser.sv
// report frame parser top level: input stage, parse stage and result register
// One beat enters per clock while the result channel accepts: a received byte or a release.
// Each accepted beat gives one result beat, passing the input register, then the parse
// update into the result register. The rate is one beat per cycle, set by the state update
// of the parse stage; back-pressure on the result channel stalls the input after the one beat
// held in the input register.
module xor_checked_report_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [xcrfp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [xcrfp_pkg::BYTE_W-1:0]    wr_data,
	xcrfp_in_if.sink                        req,
	xcrfp_out_if.source                     rsp
);
	import xcrfp_pkg::*;

	codes_t            codes;
	result_t           result;
	result_t           result_q;
	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;

	xcrfp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.codes    (codes)
	);

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.op;
			byte_s1 <= req.rx_byte;
		end
	end

	xcrfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.codes   (codes),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.ack_seen     = result_q.ack_seen;
	assign rsp.nak_seen     = result_q.nak_seen;
	assign rsp.report_ready = result_q.report_ready;
	assign rsp.report_id    = result_q.report_id;
	assign rsp.report_index = result_q.report_index;
	assign rsp.report_value = result_q.report_value;

`include "xor_checked_report_frame_parser_macros.svh"

	`XCRFP_ASSERT_IMPL(a_stall_means_busy, !req.ready, valid_s1 && out_valid_q, "input stalled with a free stage")
	`XCRFP_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "parsed beat did not reach the result register")
	`XCRFP_ASSERT_NEXT(a_out_holds, out_valid_q && !rsp.ready, out_valid_q, "result beat lost while stalled")

endmodule

### bench/tb_xor_checked_report_frame_parser.sv
`timescale 1ns / 100ps
// self-checking bench for the xor checked report frame parser
module tb_xor_checked_report_frame_parser;
	import xcrfp_pkg::*;

	localparam int STALL_LIMIT = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [BYTE_W-1:0]    wr_data;

	xcrfp_in_if  req_if();
	xcrfp_out_if rsp_if();

	xor_checked_report_frame_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	// parser state as predicted
	codes_t             model_codes;
	logic               model_in_frame;
	logic [POS_W-1:0]   model_pos;
	logic [BYTE_W-1:0]  model_xor;
	logic               model_held;
	logic [BYTE_W-1:0]  model_id;
	logic [BYTE_W-1:0]  model_idx;
	logic [VALUE_W-1:0] model_value;

	result_t status_q[$];

	int errors;
	int beats;
	int n_reports;
	int n_dropped;
	int n_ack;
	int n_nak;
	int n_release;

	int burst_left;
	bit send_gaps;
	bit rx_free;
	int rx_hold_req;
	int hold_cnt;
	int run_left;
	bit run_ready;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic parse_beat(input logic op, input logic [BYTE_W-1:0] b, output result_t r);
		r = '0;
		if (op == OP_RELEASE) begin
			model_held = 1'b0;
			n_release++;
		end else if (!model_in_frame && b == model_codes.ack_code) begin
			r.ack_seen = 1'b1;
			n_ack++;
		end else if (!model_in_frame && b == model_codes.nak_code) begin
			r.nak_seen = 1'b1;
			n_nak++;
		end else if (!model_held) begin
			if (!model_in_frame) begin
				if (b == model_codes.start_code) begin
					model_in_frame = 1'b1;
					model_pos = POS_ID;
					model_xor = b;
				end
			end else begin
				model_xor = model_xor ^ b;
				case (model_pos)
					POS_ID: model_id = b;
					POS_INDEX: model_idx = b;
					POS_VAL_H: model_value[15:8] = b;
					POS_VAL_L: model_value[7:0] = b;
					default: ;
				endcase
				if (model_pos == POS_CHECK || model_pos == POS_IDLE || model_pos > POS_CHECK) begin
					if (model_pos == POS_CHECK && model_xor == '0) begin
						model_held = 1'b1;
						n_reports++;
					end else begin
						n_dropped++;
					end
					model_in_frame = 1'b0;
					model_pos = POS_IDLE;
				end else begin
					model_pos = model_pos + POS_W'(1);
				end
			end
		end
		r.report_ready = model_held;
		if (model_held) begin
			r.report_id = model_id;
			r.report_index = model_idx;
			r.report_value = model_value;
		end
	endtask

	task automatic send_beat(input logic op, input logic [BYTE_W-1:0] b);
		result_t r;
		if (send_gaps && burst_left <= 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.rx_byte <= b;
		do @(posedge clk); while (!req_if.ready);
		burst_left--;
		parse_beat(op, b, r);
		status_q.push_back(r);
		beats++;
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] idx,
		input logic [VALUE_W-1:0] value, input logic [BYTE_W-1:0] spoil);
		logic [BYTE_W-1:0] chk;
		chk = model_codes.start_code ^ id ^ idx ^ value[15:8] ^ value[7:0] ^ spoil;
		send_beat(OP_BYTE, model_codes.start_code);
		send_beat(OP_BYTE, id);
		send_beat(OP_BYTE, idx);
		send_beat(OP_BYTE, value[15:8]);
		send_beat(OP_BYTE, value[7:0]);
		send_beat(OP_BYTE, chk);
	endtask

	task automatic drain;
		req_if.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] n);
		wr_en <= 1'b1;
		wr_index <= REG_START;
		wr_data <= s;
		@(posedge clk);
		wr_index <= REG_ACK;
		wr_data <= a;
		@(posedge clk);
		wr_index <= REG_NAK;
		wr_data <= n;
		@(posedge clk);
		wr_en <= 1'b0;
		model_codes.start_code = s;
		model_codes.ack_code = a;
		model_codes.nak_code = n;
	endtask

	task automatic random_traffic(input int count);
		int first;
		int k;
		first = beats;
		while (beats - first < count) begin
			k = $urandom_range(0, 99);
			if (k < 55) begin
				if (model_held && $urandom_range(0, 3) != 0)
					send_beat(OP_RELEASE, 8'($urandom));
				if ($urandom_range(0, 4) == 0)
					send_frame(model_codes.ack_code, model_codes.nak_code,
						16'($urandom), 8'h00);
				else
					send_frame(8'($urandom), 8'($urandom), 16'($urandom), 8'h00);
			end else if (k < 65) begin
				send_frame(8'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom_range(1, 255)));
			end else if (k < 70) begin
				send_beat(OP_BYTE, model_codes.start_code);
				repeat ($urandom_range(1, 4)) send_beat(OP_BYTE, 8'($urandom));
			end else if (k < 85) begin
				send_beat(OP_RELEASE, 8'($urandom));
			end else if (k < 92) begin
				send_beat(OP_BYTE, $urandom_range(0, 1) ? model_codes.ack_code
					: model_codes.nak_code);
			end else begin
				send_beat(1'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic test_ack_nak;
		send_beat(OP_RELEASE, 8'h00);
		send_beat(OP_BYTE, ACK_RESET);
		send_beat(OP_BYTE, NAK_RESET);
		send_beat(OP_BYTE, 8'hFF);
	endtask

	task automatic test_frame_hold;
		send_frame(8'hFF, 8'h00, 16'hFFFF, 8'h00);
		send_beat(OP_BYTE, START_RESET);
		send_beat(OP_BYTE, ACK_RESET);
		send_beat(OP_RELEASE, 8'hFF);
	endtask

	task automatic test_codes_inside_frame;
		send_beat(OP_BYTE, model_codes.start_code);
		send_beat(OP_BYTE, model_codes.ack_code);
		send_beat(OP_RELEASE, 8'h00);
		send_beat(OP_BYTE, model_codes.nak_code);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h80);
		send_beat(OP_BYTE, model_codes.start_code ^ model_codes.ack_code
			^ model_codes.nak_code ^ 8'h80);
		send_beat(OP_RELEASE, 8'h00);
	endtask

	task automatic test_bad_checksum;
		send_frame(8'h00, 8'hFF, 16'h8001, 8'h01);
		send_beat(OP_BYTE, 8'h55);
	endtask

	task automatic test_code_collision;
		drain();
		set_codes(8'hFF, 8'hFF, 8'hFF);
		send_beat(OP_BYTE, 8'hFF);
		drain();
		set_codes(8'h00, 8'h01, 8'h00);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h01);
		drain();
	endtask

	task automatic test_backpressure;
		send_gaps = 1'b0;
		rx_free = 1'b1;
		set_codes(8'hA5, 8'h06, 8'h15);
		rx_hold_req = 80;
		random_traffic(40);
		drain();
	endtask

	task automatic test_random_phases;
		send_gaps = 1'b0;
		rx_free = 1'b1;
		set_codes(8'h00, 8'hFF, 8'h80);
		random_traffic(200);
		drain();
		send_gaps = 1'b1;
		rx_free = 1'b0;
		set_codes(8'hFF, 8'h00, 8'h7F);
		random_traffic(200);
		drain();
		set_codes(8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(200);
		drain();
		send_gaps = 1'b0;
		set_codes(8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(200);
		drain();
	endtask

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
		input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	// result side: checks each accepted beat, then drives ready
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (status_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat", $time);
			end else begin
				want = status_q.pop_front();
				check_field("ack_seen", VALUE_W'(want.ack_seen), VALUE_W'(rsp_if.ack_seen));
				check_field("nak_seen", VALUE_W'(want.nak_seen), VALUE_W'(rsp_if.nak_seen));
				check_field("report_ready", VALUE_W'(want.report_ready),
					VALUE_W'(rsp_if.report_ready));
				check_field("report_id", VALUE_W'(want.report_id), VALUE_W'(rsp_if.report_id));
				check_field("report_index", VALUE_W'(want.report_index),
					VALUE_W'(rsp_if.report_index));
				check_field("report_value", want.report_value, rsp_if.report_value);
			end
		end
		if (rx_hold_req > 0) begin
			hold_cnt = rx_hold_req;
			rx_hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_if.ready <= 1'b0;
		end else if (rx_free) begin
			rsp_if.ready <= 1'b1;
		end else begin
			if (run_left <= 0) begin
				run_ready = !run_ready;
				run_left = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 5);
			end
			run_left--;
			rsp_if.ready <= run_ready;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("xor_checked_report_frame_parser: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_START;
		wr_data = '0;
		req_if.valid = 1'b0;
		req_if.op = OP_BYTE;
		req_if.rx_byte = '0;
		rsp_if.ready = 1'b0;
		model_codes.start_code = START_RESET;
		model_codes.ack_code = ACK_RESET;
		model_codes.nak_code = NAK_RESET;
		model_in_frame = 1'b0;
		model_pos = POS_IDLE;
		model_xor = '0;
		model_held = 1'b0;
		model_id = '0;
		model_idx = '0;
		model_value = '0;
		send_gaps = 1'b1;
		rx_free = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ack_nak();
		test_frame_hold();
		test_codes_inside_frame();
		test_bad_checksum();
		test_code_collision();
		test_backpressure();
		test_random_phases();
		drain();
		repeat (6) @(posedge clk);
		$display("sent %0d beats: %0d reports held, %0d frames dropped, %0d releases",
			beats, n_reports, n_dropped, n_release);
		$display("flags seen: %0d ack, %0d nak, over reset, colliding and random codes",
			n_ack, n_nak);
		if (errors == 0)
			$display("xor_checked_report_frame_parser: match");
		else
			$display("xor_checked_report_frame_parser: mismatch");
		$finish;
	end

endmodule
